/* hdl/lph_pkg.sv */
// Shared types, constants and codes for the linear-probe hash map.
package lph_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int ENTRY_W     = ADDR_W + 1;
    localparam int KEY_W       = 64;
    localparam int VALUE_W     = 32;
    localparam int KB_W        = 4;

    localparam logic [KEY_W-1:0] FNV_OFFSET   = 64'hCBF29CE484222325;
    // The FNV prime is 2**40 + 0x1B3, so a multiply is a narrow product plus a shift.
    localparam logic [8:0]       FNV_PRIME_LO = 9'h1B3;
    localparam int               FNV_PRIME_SH = 40;

    localparam logic [ENTRY_W+1:0] FULL_MARK = (ENTRY_W + 2)'(TABLE_DEPTH * 3);

    localparam logic [KB_W-1:0] KEY_BYTES_RESET = 4'd8;

    localparam logic [1:0] REQ_GET    = 2'd0;
    localparam logic [1:0] REQ_UPSERT = 2'd1;
    localparam logic [1:0] REQ_WRITE  = 2'd2;

    localparam logic [2:0] ST_FOUND   = 3'd0;
    localparam logic [2:0] ST_CREATED = 3'd1;
    localparam logic [2:0] ST_ABSENT  = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_WRITTEN = 3'd4;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [KEY_W-1:0]   key;
        logic [7:0]         slot_in;
        logic [VALUE_W-1:0] value_in;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         slot;
        logic [VALUE_W-1:0] value;
        logic [8:0]         entry_count;
    } rsp_t;

endpackage

/* hdl/linear_probe_hash_map.sv */
// Top level of the linear-probe hash map: sequencer, key/value memories and slot marks.
//
//   channel   ports               direction  content
//   config    cfg_we, cfg_wdata   in         key byte count register
//   request   s_valid/s_ready     in         req_t: type, key, slot, value
//   result    m_valid/m_ready     out        rsp_t: status, slot, value, entry count
//
// A value write or an unknown request goes straight to the done state, which registers
// its result. A get or upsert first hashes nb key bytes, nb the hashed key byte count
// (one FNV step each in the shared hash unit), then walks the occupied slots from the
// home slot; each probe step waits on the registered read of the key memory. Requests
// are taken one at a time, in the idle state only; the next beat can be taken in the
// cycle in which the result appears.
// Reset clears the slot marks, the entry count and sets the key byte count to 8.
// The next request is taken while a finished result waits in the output register; a
// result that is ready while the previous one still waits holds the block until then.
module linear_probe_hash_map import lph_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic [KB_W-1:0] cfg_wdata,
    input  logic            s_valid,
    output logic            s_ready,
    input  req_t            s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output rsp_t            m_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HASH  = 3'd1;
    localparam logic [2:0] S_PROBE = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [KB_W-1:0]        key_bytes_reg, key_bytes_next;
    logic [KB_W-1:0]        nb_reg, nb_next;
    logic [KB_W-1:0]        nb_eff;
    req_t                   req_reg, req_next;
    logic [ADDR_W-1:0]      idx_reg, idx_next;
    logic [ADDR_W-1:0]      cnt_reg, cnt_next;
    logic [2:0]             status_reg, status_next;
    logic [7:0]             slot_reg, slot_next;
    logic [VALUE_W-1:0]     value_reg, value_next;
    logic [ENTRY_W-1:0]     entry_reg, entry_next;
    logic [TABLE_DEPTH-1:0] occ_reg, occ_next;
    logic                   m_valid_reg, m_valid_next;
    rsp_t                   m_data_reg, m_data_next;

    logic [KEY_W-1:0]   key_mem [TABLE_DEPTH];
    logic [VALUE_W-1:0] val_mem [TABLE_DEPTH];
    logic [KEY_W-1:0]   key_rd_reg;
    logic [VALUE_W-1:0] val_rd_reg;

    logic               key_we;
    logic               val_we;
    logic [ADDR_W-1:0]  val_waddr;
    logic [VALUE_W-1:0] val_wdata;

    logic             accept;
    logic             hash_start;
    logic             hash_done;
    logic [KEY_W-1:0] hash;
    logic             key_hit;
    logic             table_full;

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        if (key_bytes_reg == 4'd0) begin
            nb_eff = 4'd1;
        end else if (key_bytes_reg > 4'd8) begin
            nb_eff = 4'd8;
        end else begin
            nb_eff = key_bytes_reg;
        end
    end

    assign hash_start = accept &&
                        (s_data.req_type == REQ_GET || s_data.req_type == REQ_UPSERT);

    lph_hash u_hash (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (hash_start),
        .key       (s_data.key),
        .num_bytes (nb_eff),
        .done      (hash_done),
        .hash      (hash)
    );

    // Only the low nb bytes take part in the key comparison.
    always_comb begin
        key_hit = 1'b1;
        for (int b = 0; b < 8; b++) begin
            if (KB_W'(b) < nb_reg && key_rd_reg[8*b +: 8] != req_reg.key[8*b +: 8]) begin
                key_hit = 1'b0;
            end
        end
    end

    assign table_full = ({entry_reg, 2'b00} >= FULL_MARK);

    always_comb begin
        state_next     = state_reg;
        key_bytes_next = key_bytes_reg;
        nb_next        = nb_reg;
        req_next       = req_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        status_next    = status_reg;
        slot_next      = slot_reg;
        value_next     = value_reg;
        entry_next     = entry_reg;
        occ_next       = occ_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        key_we         = 1'b0;
        val_we         = 1'b0;
        val_waddr      = idx_reg;
        val_wdata      = '0;

        if (cfg_we) begin
            key_bytes_next = cfg_wdata;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    req_next    = s_data;
                    nb_next     = nb_eff;
                    status_next = ST_ABSENT;
                    slot_next   = '0;
                    value_next  = '0;
                    case (s_data.req_type)
                        REQ_GET, REQ_UPSERT: begin
                            state_next = S_HASH;
                        end
                        REQ_WRITE: begin
                            state_next = S_DONE;
                            if (occ_reg[s_data.slot_in]) begin
                                val_we      = 1'b1;
                                val_waddr   = s_data.slot_in;
                                val_wdata   = s_data.value_in;
                                status_next = ST_WRITTEN;
                                slot_next   = s_data.slot_in;
                                value_next  = s_data.value_in;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    idx_next   = hash[ADDR_W-1:0];
                    cnt_next   = '0;
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                if (!occ_reg[idx_reg]) begin
                    state_next = S_DONE;
                    if (req_reg.req_type == REQ_UPSERT) begin
                        if (table_full) begin
                            status_next = ST_FULL;
                        end else begin
                            key_we            = 1'b1;
                            val_we            = 1'b1;
                            occ_next[idx_reg] = 1'b1;
                            entry_next        = entry_reg + 1'b1;
                            status_next       = ST_CREATED;
                            slot_next         = 8'(idx_reg);
                        end
                    end
                end else begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if (key_hit) begin
                    status_next = ST_FOUND;
                    slot_next   = 8'(idx_reg);
                    value_next  = val_rd_reg;
                    state_next  = S_DONE;
                end else if (cnt_reg == ADDR_W'(TABLE_DEPTH - 1)) begin
                    // Every slot was visited without a match or a free slot.
                    status_next = (req_reg.req_type == REQ_UPSERT) ? ST_FULL : ST_ABSENT;
                    state_next  = S_DONE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_PROBE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.status       = status_reg;
                    m_data_next.slot         = slot_reg;
                    m_data_next.value        = value_reg;
                    m_data_next.entry_count  = entry_reg;
                    state_next               = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            key_bytes_reg <= KEY_BYTES_RESET;
            entry_reg     <= '0;
            occ_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            key_bytes_reg <= key_bytes_next;
            entry_reg     <= entry_next;
            occ_reg       <= occ_next;
            m_valid_reg   <= m_valid_next;
        end
        nb_reg     <= nb_next;
        req_reg    <= req_next;
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        value_reg  <= value_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[idx_reg] <= req_reg.key;
        end
        key_rd_reg <= key_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (val_we) begin
            val_mem[val_waddr] <= val_wdata;
        end
        val_rd_reg <= val_mem[idx_reg];
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    // An upsert never claims a slot once the table is three quarters full.
    a_load_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ({entry_reg, 2'b00} <= FULL_MARK))
        else $error("entry count passed the load limit");

    // The entry count only ever grows by one, and only through a slot claim.
    a_entry_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && entry_reg != $past(entry_reg)) |->
        (entry_reg == $past(entry_reg) + 1'b1 && $past(state_reg) == S_PROBE))
        else $error("entry count changed without a slot claim");

    // A claimed slot was free before and is marked occupied afterward.
    a_claim_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        key_we |=> (occ_reg[$past(idx_reg)] && !$past(occ_reg[idx_reg])))
        else $error("slot claim did not take a free slot");
`endif

endmodule

/* hdl/lph_hash.sv */
// Byte-serial FNV-1a 64-bit hash unit, one key byte per cycle.
module lph_hash import lph_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [KEY_W-1:0] key,
    input  logic [KB_W-1:0]  num_bytes,
    output logic             done,
    output logic [KEY_W-1:0] hash
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic [2:0]       last_reg, last_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [KEY_W-1:0] h_reg, h_next;
    logic [KEY_W-1:0] mixed;
    logic [KEY_W-1:0] product;

    assign mixed   = h_reg ^ {56'd0, key_reg[8*cnt_reg +: 8]};
    assign product = KEY_W'(mixed * KEY_W'(FNV_PRIME_LO))
                   + {mixed[KEY_W-FNV_PRIME_SH-1:0], {FNV_PRIME_SH{1'b0}}};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        last_next = last_reg;
        key_next  = key_reg;
        h_next    = h_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 3'd0;
            last_next = 3'(num_bytes - 4'd1);
            key_next  = key;
            h_next    = FNV_OFFSET;
        end else if (busy_reg) begin
            h_next   = product;
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == last_reg) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        last_reg <= last_next;
        key_reg  <= key_next;
        h_reg    <= h_next;
    end

    assign done = done_reg;
    assign hash = h_reg;

endmodule

/* verif/tb_linear_probe_hash_map.sv */
// Testbench for the linear-probe hash map: scoreboard class, request driver and result checks.
`timescale 1ns / 100ps

module tb_linear_probe_hash_map;
    import lph_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int STALL_LIMIT = 4000;
    localparam int FILL_MARK   = TABLE_DEPTH * 3 / 4;
    localparam int FILL_PHASE  = 8;
    localparam int PHASE_ITEMS = 66;

    logic            aclk;
    logic            aresetn;
    logic            cfg_we;
    logic [KB_W-1:0] cfg_wdata;
    logic            s_valid;
    logic            s_ready;
    req_t            s_data;
    logic            m_valid;
    logic            m_ready;
    rsp_t            m_data;

    // When set, neither side inserts idle cycles.
    bit calm;

    logic [KB_W-1:0] phase_kb [12] = '{4'd1, 4'd3, 4'd2, 4'd0, 4'd5, 4'd6,
                                       4'd7, 4'd4, 4'd8, 4'd10, 4'd15, 4'd1};

    class hash_map_scoreboard;
        logic [KEY_W-1:0]   key_mem [TABLE_DEPTH];
        logic [VALUE_W-1:0] value_mem [TABLE_DEPTH];
        bit                 taken [TABLE_DEPTH];
        int                 taken_slots [$];
        int unsigned        entries;
        logic [KB_W-1:0]    key_bytes;
        rsp_t               expected_q [$];
        int                 errors;

        function new();
            entries   = 0;
            key_bytes = KEY_BYTES_RESET;
            errors    = 0;
        endfunction

        function void set_key_bytes(logic [KB_W-1:0] kb);
            key_bytes = kb;
        endfunction

        // A byte count of zero behaves as one, anything above eight as eight.
        function int hashed_bytes();
            if (key_bytes == 0) return 1;
            if (key_bytes > 8) return 8;
            return int'(key_bytes);
        endfunction

        function logic [KEY_W-1:0] compare_mask();
            int nb;
            nb = hashed_bytes();
            if (nb == 8) return '1;
            return (64'd1 << (8 * nb)) - 64'd1;
        endfunction

        function logic [KEY_W-1:0] fnv_hash(logic [KEY_W-1:0] key);
            logic [KEY_W-1:0] h;
            h = 64'hCBF29CE484222325;
            for (int b = 0; b < hashed_bytes(); b++) begin
                h = h ^ {56'd0, key[8*b +: 8]};
                h = h * 64'h0000_0100_0000_01B3;
            end
            return h;
        endfunction

        // Walks from the home slot; stops at a matching key or at the first free slot.
        function bit find_key(logic [KEY_W-1:0] key, output int pos, output bit has_free);
            logic [KEY_W-1:0] mask;
            logic [KEY_W-1:0] h;
            int               idx;
            mask     = compare_mask();
            h        = fnv_hash(key);
            idx      = int'(h[ADDR_W-1:0]);
            has_free = 1'b0;
            pos      = 0;
            for (int n = 0; n < TABLE_DEPTH; n++) begin
                if (!taken[idx]) begin
                    has_free = 1'b1;
                    pos      = idx;
                    return 1'b0;
                end
                if (((key_mem[idx] ^ key) & mask) == '0) begin
                    pos = idx;
                    return 1'b1;
                end
                idx = (idx + 1) % TABLE_DEPTH;
            end
            return 1'b0;
        endfunction

        function void note_request(req_t r);
            rsp_t e;
            int   pos;
            bit   has_free;
            e        = '0;
            e.status = ST_ABSENT;
            case (r.req_type)
                REQ_GET: begin
                    if (find_key(r.key, pos, has_free)) begin
                        e.status = ST_FOUND;
                        e.slot   = 8'(pos);
                        e.value  = value_mem[pos];
                    end
                end
                REQ_UPSERT: begin
                    if (find_key(r.key, pos, has_free)) begin
                        e.status = ST_FOUND;
                        e.slot   = 8'(pos);
                        e.value  = value_mem[pos];
                    end else if (!has_free || entries * 4 >= TABLE_DEPTH * 3) begin
                        e.status = ST_FULL;
                    end else begin
                        key_mem[pos]   = r.key;
                        value_mem[pos] = '0;
                        taken[pos]     = 1'b1;
                        taken_slots.push_back(pos);
                        entries++;
                        e.status = ST_CREATED;
                        e.slot   = 8'(pos);
                    end
                end
                REQ_WRITE: begin
                    if (taken[r.slot_in]) begin
                        value_mem[r.slot_in] = r.value_in;
                        e.status = ST_WRITTEN;
                        e.slot   = r.slot_in;
                        e.value  = r.value_in;
                    end
                end
                default: ;
            endcase
            e.entry_count = 9'(entries);
            expected_q.push_back(e);
        endfunction

        function void check_result(rsp_t got);
            rsp_t e;
            if (expected_q.size() == 0) begin
                $error("result beat with no request outstanding: status %0d slot %0d",
                       got.status, got.slot);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, got.status);
                errors++;
            end
            if (got.slot !== e.slot) begin
                $error("slot: expected %0d, got %0d", e.slot, got.slot);
                errors++;
            end
            if (got.value !== e.value) begin
                $error("value: expected %h, got %h", e.value, got.value);
                errors++;
            end
            if (got.entry_count !== e.entry_count) begin
                $error("entry_count: expected %0d, got %0d", e.entry_count, got.entry_count);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    hash_map_scoreboard sb = new();

    linear_probe_hash_map dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic send_request(req_t r);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_request(r);
    endtask

    // Holds off new requests until every outstanding result has come back.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_key_bytes(logic [KB_W-1:0] kb);
        cfg_we    <= 1'b1;
        cfg_wdata <= kb;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_key_bytes(kb);
    endtask

    function automatic req_t make_req(logic [1:0] kind, logic [KEY_W-1:0] key,
                                      logic [7:0] slot, logic [VALUE_W-1:0] value);
        req_t r;
        r.req_type = kind;
        r.key      = key;
        r.slot_in  = slot;
        r.value_in = value;
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [KEY_W-1:0] stored_key_variant();
        logic [KEY_W-1:0] mask;
        logic [KEY_W-1:0] k;
        if (sb.taken_slots.size() == 0) return rand_key();
        k    = sb.key_mem[sb.taken_slots[$urandom_range(0, sb.taken_slots.size() - 1)]];
        mask = sb.compare_mask();
        // Bytes above the compared ones take no part in the match, so scramble them.
        if ($urandom_range(0, 1) == 1) k = (k & mask) | (rand_key() & ~mask);
        return k;
    endfunction

    function automatic req_t random_request();
        req_t r;
        int   pick;
        r    = make_req(REQ_GET, rand_key(), 8'($urandom_range(0, 255)), $urandom);
        pick = $urandom_range(0, 99);
        if (pick >= 8 && pick < 38) begin
            r.req_type = REQ_UPSERT;
        end else if (pick >= 38 && pick < 58) begin
            r.req_type = REQ_UPSERT;
            r.key      = stored_key_variant();
        end else if (pick >= 58 && pick < 78) begin
            r.key = stored_key_variant();
        end else if (pick >= 78 && pick < 96) begin
            r.req_type = REQ_WRITE;
            if (pick < 92 && sb.taken_slots.size() > 0)
                r.slot_in = 8'(sb.taken_slots[$urandom_range(0, sb.taken_slots.size() - 1)]);
        end else if (pick >= 96) begin
            r.req_type = REQ_UNKNOWN;
        end
        return r;
    endfunction

    task automatic run_directed();
        send_request(make_req(REQ_GET, '0, 8'd0, '0));
        send_request(make_req(REQ_WRITE, '0, 8'd0, '1));
        send_request(make_req(REQ_UPSERT, '0, 8'd0, '0));
        send_request(make_req(REQ_UPSERT, '1, '1, '1));
        send_request(make_req(REQ_GET, '1, 8'd0, '0));
        send_request(make_req(REQ_UPSERT, '0, 8'd0, '0));
        send_request(make_req(REQ_WRITE, '0, 8'(sb.taken_slots[0]), '1));
        send_request(make_req(REQ_GET, '0, 8'd0, '0));
        send_request(make_req(REQ_WRITE, '1, 8'(sb.taken_slots[1]), '0));
        send_request(make_req(REQ_UNKNOWN, '1, '1, '1));
        send_request(make_req(REQ_WRITE, '0, 8'd255, 32'h5A5A_A5A5));
        send_request(make_req(REQ_GET, 64'h8000_0000_0000_0000, 8'd0, '0));

        // A byte count of zero hashes and compares only the low byte.
        drain();
        write_key_bytes(4'd0);
        send_request(make_req(REQ_UPSERT, 64'hFFFF_FFFF_FFFF_FF00, 8'd0, '0));
        send_request(make_req(REQ_UPSERT, 64'h0000_0000_0000_00A5, 8'd0, '0));
        send_request(make_req(REQ_GET, 64'h1234_5678_9ABC_DEA5, 8'd0, '0));
        send_request(make_req(REQ_WRITE, '0, 8'(sb.taken_slots[2]), '1));

        drain();
        write_key_bytes(4'd15);
        send_request(make_req(REQ_GET, 64'hFFFF_FFFF_FFFF_FF00, 8'd0, '0));
        send_request(make_req(REQ_UPSERT, 64'hFFFF_FFFF_FFFF_FF00, 8'd0, '0));
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        calm = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();

        foreach (phase_kb[p]) begin
            drain();
            write_key_bytes(phase_kb[p]);
            calm = ($urandom_range(0, 3) == 0);
            if (p == FILL_PHASE) begin
                // Load the table up to its limit so that new keys are turned away.
                while (sb.entries < FILL_MARK)
                    send_request(make_req(REQ_UPSERT, rand_key(),
                                          8'($urandom_range(0, 255)), $urandom));
            end
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 49) == 0) drain();
                send_request(random_request());
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        int stall;
        m_ready <= 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            sb.check_result(m_data);
        end
    end

    initial begin
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid === 1'b1 && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready === 1'b1))
                stalled = 0;
            else
                stalled++;
        end
        $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/lph_pkg.sv
hdl/lph_hash.sv
hdl/linear_probe_hash_map.sv
verif/tb_linear_probe_hash_map.sv
